/* hw/rtl/idws_pkg.sv */
// Shared types, register indexes and helper functions for the I2C display write sequencer.
// Used by idws_front, idws_back and i2c_display_write_sequencer_core; depends on nothing.
`default_nettype none

package idws_pkg;

   localparam logic [1:0] OP_TICK    = 2'd0;
   localparam logic [1:0] OP_COMMAND = 2'd1;
   localparam logic [1:0] OP_DATA    = 2'd2;

   localparam logic [1:0] CSR_DEVICE_ADDRESS   = 2'd0;
   localparam logic [1:0] CSR_LONG_HOLD_TICKS  = 2'd1;
   localparam logic [1:0] CSR_SHORT_HOLD_TICKS = 2'd2;

   localparam logic [7:0] RESET_DEVICE_ADDRESS   = 8'h78;
   localparam logic [7:0] RESET_LONG_HOLD_TICKS  = 8'd5;
   localparam logic [7:0] RESET_SHORT_HOLD_TICKS = 8'd2;

   localparam logic [7:0] CTRL_COMMAND = 8'h00;
   localparam logic [7:0] CTRL_DATA    = 8'h40;

   localparam logic [1:0] BYTE_ADDRESS = 2'd0;
   localparam logic [1:0] BYTE_CONTROL = 2'd1;
   localparam logic [1:0] BYTE_PAYLOAD = 2'd2;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0] operation;
      logic [7:0] payload;
   } req_type;

   typedef struct packed {
      logic scl;
      logic sda;
      logic busy_res;
      logic rejected;
   } rsp_type;

   typedef struct packed {
      logic       is_request;
      logic       is_data;
      logic [7:0] payload;
   } tick_type;

   typedef struct packed {
      logic     valid;
      tick_type tick;
   } queue_head_type;

   typedef struct packed {
      logic [7:0] device_address;
      logic [7:0] long_hold_ticks;
      logic [7:0] short_hold_ticks;
   } csr_type;

   typedef enum logic [9:0] {
      PH_IDLE     = 10'b00_0000_0001,
      PH_START_A  = 10'b00_0000_0010,
      PH_START_B  = 10'b00_0000_0100,
      PH_BIT_LOW  = 10'b00_0000_1000,
      PH_BIT_HIGH = 10'b00_0001_0000,
      PH_ACK_LOW  = 10'b00_0010_0000,
      PH_ACK_HIGH = 10'b00_0100_0000,
      PH_STOP_LOW = 10'b00_1000_0000,
      PH_STOP_A   = 10'b01_0000_0000,
      PH_STOP_B   = 10'b10_0000_0000
   } phase_type;

   function automatic logic [7:0] hold_of(input logic [7:0] value);
      hold_of = (value == 8'd0) ? 8'd1 : value;
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/idws_front.sv */
// Front end of the I2C display write sequencer: classifies each tick and queues it.
// Depends on idws_pkg.
`default_nettype none

module idws_front (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_valid,
   output logic                     req_stall,
   input  idws_pkg::req_type        req_item,
   output idws_pkg::queue_head_type head,
   input  wire                      pop
);

   idws_pkg::tick_type                  entry_ff [idws_pkg::QUEUE_DEPTH];
   idws_pkg::tick_type                  tick_in;
   logic [idws_pkg::QUEUE_PTR_W-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [idws_pkg::QUEUE_PTR_W-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [idws_pkg::QUEUE_CNT_W-1:0]    count_ff, count_in;
   logic                                push;
   logic                                do_pop;

   assign req_stall = (count_ff == idws_pkg::QUEUE_CNT_W'(idws_pkg::QUEUE_DEPTH));
   assign push      = req_valid && !req_stall;
   assign do_pop    = pop && (count_ff != '0);

   always_comb begin
      tick_in.is_request = (req_item.operation == idws_pkg::OP_COMMAND) ||
                           (req_item.operation == idws_pkg::OP_DATA);
      tick_in.is_data    = (req_item.operation == idws_pkg::OP_DATA);
      tick_in.payload    = req_item.payload;
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == idws_pkg::QUEUE_PTR_W'(idws_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == idws_pkg::QUEUE_PTR_W'(idws_pkg::QUEUE_DEPTH - 1)) ?
                     '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (!push && do_pop) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= tick_in;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.tick  = entry_ff[rd_ptr_ff];

endmodule

`default_nettype wire

/* hw/rtl/idws_back.sv */
// Back end of the I2C display write sequencer: bus phase sequencer and result register.
// Depends on idws_pkg.
`default_nettype none

module idws_back (
   input  wire                      clock,
   input  wire                      reset,
   input  idws_pkg::csr_type        csr,
   input  idws_pkg::queue_head_type head,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire                      rsp_stall,
   output idws_pkg::rsp_type        rsp_item
);

   idws_pkg::phase_type phase_ff, phase_in;
   idws_pkg::phase_type target;
   logic [2:0]          bit_count_ff, bit_count_in;
   logic [1:0]          byte_select_ff, byte_select_in;
   logic [7:0]          shift_byte_ff, shift_byte_in;
   logic [7:0]          hold_count_ff, hold_count_in;
   logic [7:0]          held_payload_ff, held_payload_in;
   logic                is_data_ff, is_data_in;
   logic                scl_ff, scl_in;
   logic                sda_ff, sda_in;
   logic                rsp_valid_ff, rsp_valid_in;
   idws_pkg::rsp_type   rsp_item_ff, rsp_item_in;
   logic                enter_en;
   logic                rejected;
   logic [7:0]          long_hold;
   logic [7:0]          short_hold;

   assign pop        = head.valid && (!rsp_valid_ff || !rsp_stall);
   assign long_hold  = idws_pkg::hold_of(csr.long_hold_ticks);
   assign short_hold = idws_pkg::hold_of(csr.short_hold_ticks);

   always_comb begin
      phase_in        = phase_ff;
      bit_count_in    = bit_count_ff;
      byte_select_in  = byte_select_ff;
      shift_byte_in   = shift_byte_ff;
      hold_count_in   = hold_count_ff;
      held_payload_in = held_payload_ff;
      is_data_in      = is_data_ff;
      scl_in          = scl_ff;
      sda_in          = sda_ff;
      enter_en        = 1'b0;
      target          = idws_pkg::PH_IDLE;
      rejected        = 1'b0;

      if (pop) begin
         if (phase_ff == idws_pkg::PH_IDLE) begin
            if (head.tick.is_request) begin
               held_payload_in = head.tick.payload;
               is_data_in      = head.tick.is_data;
               shift_byte_in   = csr.device_address;
               byte_select_in  = idws_pkg::BYTE_ADDRESS;
               bit_count_in    = 3'd0;
               enter_en        = 1'b1;
               target          = idws_pkg::PH_START_A;
            end
         end else begin
            rejected = head.tick.is_request;
            if (hold_count_ff <= 8'd1) begin
               enter_en = 1'b1;
               unique case (phase_ff)
                  idws_pkg::PH_START_A: begin
                     target = idws_pkg::PH_START_B;
                  end
                  idws_pkg::PH_START_B: begin
                     byte_select_in = idws_pkg::BYTE_ADDRESS;
                     bit_count_in   = 3'd0;
                     target         = idws_pkg::PH_BIT_LOW;
                  end
                  idws_pkg::PH_BIT_LOW: begin
                     target = idws_pkg::PH_BIT_HIGH;
                  end
                  idws_pkg::PH_BIT_HIGH: begin
                     if (bit_count_ff == 3'd7) begin
                        target = idws_pkg::PH_ACK_LOW;
                     end else begin
                        bit_count_in  = bit_count_ff + 3'd1;
                        shift_byte_in = {shift_byte_ff[6:0], 1'b0};
                        target        = idws_pkg::PH_BIT_LOW;
                     end
                  end
                  idws_pkg::PH_ACK_LOW: begin
                     target = idws_pkg::PH_ACK_HIGH;
                  end
                  idws_pkg::PH_ACK_HIGH: begin
                     if (byte_select_ff >= idws_pkg::BYTE_PAYLOAD) begin
                        target = idws_pkg::PH_STOP_LOW;
                     end else begin
                        byte_select_in = byte_select_ff + 2'd1;
                        bit_count_in   = 3'd0;
                        if (byte_select_ff == idws_pkg::BYTE_ADDRESS) begin
                           shift_byte_in = is_data_ff ? idws_pkg::CTRL_DATA :
                                                        idws_pkg::CTRL_COMMAND;
                        end else begin
                           shift_byte_in = held_payload_ff;
                        end
                        target = idws_pkg::PH_BIT_LOW;
                     end
                  end
                  idws_pkg::PH_STOP_LOW: begin
                     target = idws_pkg::PH_STOP_A;
                  end
                  idws_pkg::PH_STOP_A: begin
                     target = idws_pkg::PH_STOP_B;
                  end
                  default: begin
                     target = idws_pkg::PH_IDLE;
                  end
               endcase
            end else begin
               hold_count_in = hold_count_ff - 8'd1;
            end
         end
      end

      if (enter_en) begin
         phase_in = target;
         unique case (target)
            idws_pkg::PH_START_A: begin
               scl_in = 1'b1; sda_in = 1'b1; hold_count_in = long_hold;
            end
            idws_pkg::PH_START_B: begin
               scl_in = 1'b1; sda_in = 1'b0; hold_count_in = long_hold;
            end
            idws_pkg::PH_BIT_LOW: begin
               scl_in = 1'b0; sda_in = shift_byte_in[7]; hold_count_in = short_hold;
            end
            idws_pkg::PH_BIT_HIGH: begin
               scl_in = 1'b1; sda_in = shift_byte_in[7]; hold_count_in = short_hold;
            end
            idws_pkg::PH_ACK_LOW: begin
               scl_in = 1'b0; sda_in = 1'b1; hold_count_in = short_hold;
            end
            idws_pkg::PH_ACK_HIGH: begin
               scl_in = 1'b1; sda_in = 1'b1; hold_count_in = short_hold;
            end
            idws_pkg::PH_STOP_LOW: begin
               scl_in = 1'b0; sda_in = 1'b0; hold_count_in = short_hold;
            end
            idws_pkg::PH_STOP_A: begin
               scl_in = 1'b1; sda_in = 1'b0; hold_count_in = long_hold;
            end
            idws_pkg::PH_STOP_B: begin
               scl_in = 1'b1; sda_in = 1'b1; hold_count_in = long_hold;
            end
            default: begin
               scl_in = 1'b1; sda_in = 1'b1; hold_count_in = 8'd0;
            end
         endcase
      end
   end

   always_comb begin
      rsp_item_in.scl      = scl_in;
      rsp_item_in.sda      = sda_in;
      rsp_item_in.busy_res = (phase_in != idws_pkg::PH_IDLE);
      rsp_item_in.rejected = rejected;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= idws_pkg::PH_IDLE;
         bit_count_ff    <= '0;
         byte_select_ff  <= '0;
         shift_byte_ff   <= '0;
         hold_count_ff   <= '0;
         held_payload_ff <= '0;
         is_data_ff      <= 1'b0;
         scl_ff          <= 1'b1;
         sda_ff          <= 1'b1;
         rsp_valid_ff    <= 1'b0;
      end else begin
         phase_ff        <= phase_in;
         bit_count_ff    <= bit_count_in;
         byte_select_ff  <= byte_select_in;
         shift_byte_ff   <= shift_byte_in;
         hold_count_ff   <= hold_count_in;
         held_payload_ff <= held_payload_in;
         is_data_ff      <= is_data_in;
         scl_ff          <= scl_in;
         sda_ff          <= sda_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_item_ff <= rsp_item_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

`default_nettype wire

/* hw/rtl/i2c_display_write_sequencer_core.sv */
// Top level of the I2C display write sequencer: configuration registers, front and back ends.
// Depends on idws_pkg, idws_front and idws_back.
`default_nettype none

// Every transaction on the req_ channel is one time tick and yields exactly one transaction on
// the rsp_ channel with the SCL and SDA levels after that tick, a busy flag and a rejected flag.
// A command or data write starts only on an idle tick; a request on a busy tick is dropped and
// flagged. The block takes one tick per clock cycle when the result side does not stall. A tick
// goes through a two-entry queue and then the phase sequencer, whose output register holds the
// result. Configuration writes take effect in the cycle after the write enable and belong to
// idle periods.
module i2c_display_write_sequencer_core (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  idws_pkg::req_type  req_item,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output idws_pkg::rsp_type  rsp_item,
   input  wire                csr_write_enable,
   input  wire [1:0]          csr_index,
   input  wire [7:0]          csr_write_data
);

   idws_pkg::csr_type        csr_ff, csr_in;
   idws_pkg::queue_head_type head;
   logic                     pop;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            idws_pkg::CSR_DEVICE_ADDRESS:   csr_in.device_address   = csr_write_data;
            idws_pkg::CSR_LONG_HOLD_TICKS:  csr_in.long_hold_ticks  = csr_write_data;
            idws_pkg::CSR_SHORT_HOLD_TICKS: csr_in.short_hold_ticks = csr_write_data;
            default: begin
               csr_in = csr_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.device_address   <= idws_pkg::RESET_DEVICE_ADDRESS;
         csr_ff.long_hold_ticks  <= idws_pkg::RESET_LONG_HOLD_TICKS;
         csr_ff.short_hold_ticks <= idws_pkg::RESET_SHORT_HOLD_TICKS;
      end else begin
         csr_ff <= csr_in;
      end
   end

   idws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .head      (head),
      .pop       (pop)
   );

   idws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr       (csr_ff),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

endmodule

`default_nettype wire
